@@ rtl/ffp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ffp_pkg: shared types and constants
// Field widths, register indexes and the control and token records that pass
// between the placement controller and the machine cells.
// ----------------------------------------------------------------------------
package ffp_pkg;

    localparam int ID_W    = 10;
    localparam int LIMIT_W = 7;
    localparam int MIDX_W  = 6;
    localparam int MUSE_W  = 7;

    localparam logic [0:0] CFG_STORAGE_LIMIT = 1'd0;
    localparam logic [0:0] CFG_LOAD_LIMIT    = 1'd1;

    localparam logic [LIMIT_W-1:0] STORAGE_RESET  = 7'd60;
    localparam logic [LIMIT_W-1:0] PARALLEL_SLOTS = 7'd10;
    localparam logic [LIMIT_W-1:0] DEADLINE_UNITS = 7'd2;
    localparam logic [LIMIT_W-1:0] LOAD_RESET     = 7'(PARALLEL_SLOTS * DEADLINE_UNITS);

    // broadcast from the controller to every cell
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [LIMIT_W-1:0] storage_limit;
        logic [LIMIT_W-1:0] load_limit;
        logic               clear;
        logic               cmp_en;
    } cell_ctl_t;

    // placement token handed from cell to cell
    typedef struct packed {
        logic live;
        logic pending;
        logic found;
        logic opened;
    } token_t;

endpackage
`default_nettype wire

@@ rtl/ffp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ffp_task_if / ffp_result_if: item channels
// Valid/ready channels for task ids in and placement results out.
// ----------------------------------------------------------------------------
interface ffp_task_if;
    logic       valid;
    logic       ready;
    logic [9:0] task_id;

    modport source (output valid, output task_id, input ready);
    modport sink   (input valid, input task_id, output ready);
endinterface

interface ffp_result_if;
    logic       valid;
    logic       ready;
    logic [5:0] machine_index;
    logic       opened_new;
    logic       no_room;
    logic [6:0] machines_in_use;

    modport source (output valid, output machine_index, output opened_new,
                    output no_room, output machines_in_use, input ready);
    modport sink   (input valid, input machine_index, input opened_new,
                    input no_room, input machines_in_use, output ready);
endinterface
`default_nettype wire

@@ rtl/first_fit_task_placement_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_task_placement_unit: first-fit placement with storage affinity
// Places each task id on the first open machine that holds the id or has a
// free slot, load below the limit; otherwise opens a new one, if any is left.
// ----------------------------------------------------------------------------
// Every machine cell reads its id store one slot per cycle in parallel, then a
// placement token walks the row of cells one machine per cycle. One item is in
// flight at a time, and a new item is taken once the previous result has been
// collected.
module first_fit_task_placement_unit #(
    parameter int MAX_MACHINES      = 64,
    parameter int SLOTS_PER_MACHINE = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_we,
    input  wire  [0:0]          cfg_index,
    input  wire  [6:0]          cfg_data,
    ffp_task_if.sink            task_in,
    ffp_result_if.source        result_out
);
    import ffp_pkg::*;

    localparam int AW = (SLOTS_PER_MACHINE > 1) ? $clog2(SLOTS_PER_MACHINE) : 1;
    localparam int CW = $clog2(SLOTS_PER_MACHINE + 1);
    localparam int IW = $clog2(MAX_MACHINES);
    localparam int OW = $clog2(MAX_MACHINES + 1);

    typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_WAIT, ST_INJECT, ST_CHAIN} state_t;

    state_t             state_reg;
    logic [ID_W-1:0]    id_reg;
    logic [LIMIT_W-1:0] storage_limit_reg;
    logic [LIMIT_W-1:0] load_limit_reg;
    logic [AW-1:0]      addr_reg;
    logic [AW-1:0]      cmp_addr_reg;
    logic               cmp_en_reg;
    logic               clear_reg;
    logic [OW-1:0]      open_cnt_reg;
    logic               out_valid_reg;
    logic [MIDX_W-1:0]  out_index_reg;
    logic               out_opened_reg;
    logic               out_no_room_reg;
    logic [MUSE_W-1:0]  out_use_reg;

    cell_ctl_t          ctl;
    token_t             tok [MAX_MACHINES+1];
    logic [IW-1:0]      idx [MAX_MACHINES+1];
    logic               accept;
    logic [OW-1:0]      open_cnt_next;

    assign task_in.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept = task_in.valid && task_in.ready;

    always_comb
    begin
        ctl.id            = id_reg;
        ctl.storage_limit = storage_limit_reg;
        ctl.load_limit    = load_limit_reg;
        ctl.clear         = clear_reg;
        ctl.cmp_en        = cmp_en_reg;
    end

    always_comb
    begin
        tok[0].live    = (state_reg == ST_INJECT);
        tok[0].pending = 1'b1;
        tok[0].found   = 1'b0;
        tok[0].opened  = 1'b0;
        idx[0]         = '0;
    end

    for (genvar g = 0; g < MAX_MACHINES; g++)
    begin : g_cell
        ffp_cell #(
            .SLOTS    (SLOTS_PER_MACHINE),
            .AW       (AW),
            .CW       (CW),
            .IW       (IW),
            .MY_INDEX (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .rd_addr  (addr_reg),
            .cmp_addr (cmp_addr_reg),
            .tok_in   (tok[g]),
            .idx_in   (idx[g]),
            .tok_out  (tok[g+1]),
            .idx_out  (idx[g+1])
        );
    end

    assign open_cnt_next = open_cnt_reg + OW'(tok[MAX_MACHINES].opened);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            id_reg            <= '0;
            storage_limit_reg <= STORAGE_RESET;
            load_limit_reg    <= LOAD_RESET;
            addr_reg          <= '0;
            cmp_addr_reg      <= '0;
            cmp_en_reg        <= 1'b0;
            clear_reg         <= 1'b0;
            open_cnt_reg      <= '0;
            out_valid_reg     <= 1'b0;
            out_index_reg     <= '0;
            out_opened_reg    <= 1'b0;
            out_no_room_reg   <= 1'b0;
            out_use_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STORAGE_LIMIT: storage_limit_reg <= cfg_data;
                    CFG_LOAD_LIMIT:    load_limit_reg    <= cfg_data;
                    default:           ;
                endcase
            end
            if (out_valid_reg && result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            cmp_addr_reg <= addr_reg;
            clear_reg    <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    cmp_en_reg <= 1'b0;
                    if (accept)
                    begin
                        id_reg    <= task_in.task_id;
                        addr_reg  <= '0;
                        clear_reg <= 1'b1;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    cmp_en_reg <= 1'b1;
                    if (32'(addr_reg) == SLOTS_PER_MACHINE - 1)
                    begin
                        state_reg <= ST_WAIT;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                ST_WAIT:
                begin
                    // last compare lands this cycle
                    cmp_en_reg <= 1'b0;
                    state_reg  <= ST_INJECT;
                end
                ST_INJECT:
                begin
                    cmp_en_reg <= 1'b0;
                    state_reg  <= ST_CHAIN;
                end
                ST_CHAIN:
                begin
                    cmp_en_reg <= 1'b0;
                    if (tok[MAX_MACHINES].live)
                    begin
                        open_cnt_reg    <= open_cnt_next;
                        out_valid_reg   <= 1'b1;
                        out_index_reg   <= tok[MAX_MACHINES].found ?
                                           MIDX_W'(idx[MAX_MACHINES]) : '0;
                        out_opened_reg  <= tok[MAX_MACHINES].opened;
                        out_no_room_reg <= !tok[MAX_MACHINES].found;
                        out_use_reg     <= MUSE_W'(open_cnt_next);
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.machine_index   = out_index_reg;
    assign result_out.opened_new      = out_opened_reg;
    assign result_out.no_room         = out_no_room_reg;
    assign result_out.machines_in_use = out_use_reg;

    // the token leaves the row only while the controller waits for it
    a_tail_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
        tok[MAX_MACHINES].live |-> (state_reg == ST_CHAIN))
        else $error("placement token left the row outside the chain phase");

    // no room is reported only when every machine is open
    a_no_room_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_no_room_reg) |-> (32'(open_cnt_reg) == MAX_MACHINES))
        else $error("no_room reported with a machine still unopened");

    // a result is registered in the cycle after the token reaches the end of the row
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        tok[MAX_MACHINES].live |=> out_valid_reg)
        else $error("result not registered after token completed");

endmodule
`default_nettype wire

@@ rtl/ffp_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ffp_cell: one machine
// Holds the machine's id store, id count and load. Scans its store against
// the broadcast id, then evaluates the placement token once it passes by.
// ----------------------------------------------------------------------------
module ffp_cell #(
    parameter int SLOTS    = 64,
    parameter int AW       = 6,
    parameter int CW       = 7,
    parameter int IW       = 6,
    parameter int MY_INDEX = 0
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  ffp_pkg::cell_ctl_t    ctl,
    input  wire  [AW-1:0]         rd_addr,
    input  wire  [AW-1:0]         cmp_addr,
    input  ffp_pkg::token_t       tok_in,
    input  wire  [IW-1:0]         idx_in,
    output ffp_pkg::token_t       tok_out,
    output logic [IW-1:0]         idx_out
);
    import ffp_pkg::*;

    logic [ID_W-1:0]    mem [SLOTS];
    logic [ID_W-1:0]    rdata_reg;
    logic               open_reg;
    logic [CW-1:0]      count_reg;
    logic [LIMIT_W-1:0] load_reg;
    logic               has_reg;
    token_t             tok_reg;
    logic [IW-1:0]      idx_reg;

    logic   hit;
    logic   slot_free;
    logic   fits;
    logic   claim;
    logic   open_new;
    token_t tok_next;

    assign hit = ctl.cmp_en && (32'(cmp_addr) < 32'(count_reg)) && (rdata_reg == ctl.id);
    assign slot_free = (32'(count_reg) < 32'(ctl.storage_limit)) && (32'(count_reg) < SLOTS);
    assign fits = open_reg && (has_reg || slot_free) && (load_reg < ctl.load_limit);
    assign claim = tok_in.live && tok_in.pending && fits;
    assign open_new = tok_in.live && tok_in.pending && !open_reg;

    always_comb
    begin
        tok_next.live    = tok_in.live;
        tok_next.pending = tok_in.pending && open_reg && !fits;
        tok_next.found   = tok_in.found || claim || open_new;
        tok_next.opened  = tok_in.opened || open_new;
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_addr];
        if (open_new)
        begin
            mem[0] <= ctl.id;
        end
        else if (claim && !has_reg)
        begin
            mem[count_reg[AW-1:0]] <= ctl.id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            count_reg <= '0;
            load_reg  <= '0;
            has_reg   <= 1'b0;
            tok_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            idx_reg <= (claim || open_new) ? IW'(MY_INDEX) : idx_in;
            if (ctl.clear)
            begin
                has_reg <= 1'b0;
            end
            else if (hit)
            begin
                has_reg <= 1'b1;
            end
            if (open_new)
            begin
                open_reg  <= 1'b1;
                count_reg <= CW'(1);
                load_reg  <= LIMIT_W'(1);
            end
            else if (claim)
            begin
                load_reg <= load_reg + 1'b1;
                if (!has_reg)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule
`default_nettype wire

@@ test/first_fit_task_placement_unit_test.sv @@
// ----------------------------------------------------------------------------
// first_fit_task_placement_unit_test: self-checking placement regression
// Streams task ids through the unit under randomized handshake timing,
// predicts every placement with a first-fit machine table of its own and
// compares each result item field by field across several limit settings.
// ----------------------------------------------------------------------------
module first_fit_task_placement_unit_test;
    import ffp_pkg::*;

    localparam int MACHINES = 64;
    localparam int SLOTS    = 64;
    localparam int LIMIT    = 2000000;

    typedef struct packed {
        logic [MIDX_W-1:0] machine_index;
        logic              opened_new;
        logic              no_room;
        logic [MUSE_W-1:0] machines_in_use;
    } placement_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [6:0] cfg_data;

    ffp_task_if   task_ch();
    ffp_result_if res_ch();

    first_fit_task_placement_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .task_in    (task_ch),
        .result_out (res_ch)
    );

    // machine table mirrored from the accepted items
    logic [ID_W-1:0]    held_ids [MACHINES][SLOTS];
    int unsigned        held_count [MACHINES];
    int unsigned        run_load [MACHINES];
    int unsigned        machines_open;
    logic [LIMIT_W-1:0] storage_cap;
    logic [LIMIT_W-1:0] load_cap;

    logic [ID_W-1:0] pending_ids [$];
    placement_t      expected_places [$];

    int  failures;
    int  cycle_count;
    int  ids_sent;
    int  places_checked;
    int  opens_seen;
    int  full_seen;
    int  send_gap;
    int  recv_stall;
    bit  quiet_send;
    bit  quiet_recv;
    bit  long_hold;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic placement_t place_task(logic [ID_W-1:0] id);
        placement_t  p;
        int unsigned cap;
        bit          has;
        cap = (storage_cap < SLOTS) ? storage_cap : SLOTS;
        p = '0;
        for (int m = 0; m < machines_open; m++)
        begin
            has = 1'b0;
            for (int k = 0; k < held_count[m]; k++)
                if (held_ids[m][k] == id)
                    has = 1'b1;
            if ((has || held_count[m] < cap) && run_load[m] < load_cap)
            begin
                if (!has)
                begin
                    held_ids[m][held_count[m]] = id;
                    held_count[m]++;
                end
                run_load[m]++;
                p.machine_index   = MIDX_W'(m);
                p.machines_in_use = MUSE_W'(machines_open);
                return p;
            end
        end
        if (machines_open < MACHINES)
        begin
            held_ids[machines_open][0] = id;
            held_count[machines_open] = 1;
            run_load[machines_open] = 1;
            p.machine_index = MIDX_W'(machines_open);
            p.opened_new = 1'b1;
            machines_open++;
            p.machines_in_use = MUSE_W'(machines_open);
            return p;
        end
        p.no_room = 1'b1;
        p.machines_in_use = MUSE_W'(machines_open);
        return p;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        failures++;
    endtask

    task automatic write_limit(logic [0:0] idx, logic [6:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_STORAGE_LIMIT)
            storage_cap = value;
        else
            load_cap = value;
    endtask

    task automatic wait_drained();
        while (pending_ids.size() > 0 || task_ch.valid || expected_places.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // pool 0 draws the whole id range; otherwise a small pool scrambled by a mask
    task automatic queue_ids(int count, int pool, logic [ID_W-1:0] mask);
        for (int i = 0; i < count; i++)
            if (pool == 0)
                pending_ids.insert(pending_ids.size(), ID_W'($urandom_range(0, 1023)));
            else
                pending_ids.insert(pending_ids.size(),
                                   ID_W'($urandom_range(0, pool - 1)) ^ mask);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_ch.valid   <= 1'b0;
            task_ch.task_id <= '0;
            send_gap        <= 0;
        end
        else
        begin
            if (task_ch.valid && task_ch.ready)
            begin
                expected_places.insert(expected_places.size(), place_task(task_ch.task_id));
                ids_sent++;
                if ($urandom_range(0, 99) == 0)
                    quiet_send = ~quiet_send;
            end
            if (!(task_ch.valid && !task_ch.ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap      <= send_gap - 1;
                    task_ch.valid <= 1'b0;
                end
                else if (pending_ids.size() > 0)
                begin
                    task_ch.valid   <= 1'b1;
                    task_ch.task_id <= pending_ids.pop_front();
                    send_gap        <= quiet_send ? 0 : $urandom_range(0, 12);
                end
                else
                    task_ch.valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        placement_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            recv_stall   <= 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_places.size() == 0)
                begin
                    report_mismatch("unexpected result item", 1, 0);
                end
                else
                begin
                    want = expected_places.pop_front();
                    places_checked++;
                    if (want.opened_new) opens_seen++;
                    if (want.no_room) full_seen++;
                    if (res_ch.no_room != want.no_room)
                        report_mismatch("no_room", res_ch.no_room, want.no_room);
                    if (res_ch.opened_new != want.opened_new)
                        report_mismatch("opened_new", res_ch.opened_new, want.opened_new);
                    if (res_ch.machine_index != want.machine_index)
                        report_mismatch("machine_index", res_ch.machine_index,
                                        want.machine_index);
                    if (res_ch.machines_in_use != want.machines_in_use)
                        report_mismatch("machines_in_use", res_ch.machines_in_use,
                                        want.machines_in_use);
                end
                if ($urandom_range(0, 99) == 0)
                    quiet_recv = ~quiet_recv;
                recv_stall <= quiet_recv ? 0 : $urandom_range(0, 12);
                res_ch.ready <= 1'b0;
            end
            else if (long_hold)
                res_ch.ready <= 1'b0;
            else if (recv_stall > 0)
            begin
                recv_stall   <= recv_stall - 1;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // hold the result side off for a long stretch while ids keep coming
    initial
    begin
        long_hold = 1'b0;
        wait (ids_sent >= 500);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (1500) @(posedge clk);
        long_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [ID_W-1:0] directed [$];
        failures = 0;
        cycle_count = 0;
        ids_sent = 0;
        places_checked = 0;
        opens_seen = 0;
        full_seen = 0;
        quiet_send = 1'b0;
        quiet_recv = 1'b0;
        machines_open = 0;
        storage_cap = STORAGE_RESET;
        load_cap = LOAD_RESET;
        for (int m = 0; m < MACHINES; m++)
        begin
            held_count[m] = 0;
            run_load[m] = 0;
        end
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset limits: repeats, extremes, single-bit and alternating-bit ids
        directed = '{10'd0, 10'd1023, 10'd0, 10'd0, 10'd1023, 10'd512, 10'd1, 10'd2,
                     10'd4, 10'd8, 10'd16, 10'd32, 10'd64, 10'd128, 10'd256, 10'd511,
                     10'd512, 10'd0, 10'd1023, 10'd682, 10'd341};
        foreach (directed[i])
            pending_ids.insert(pending_ids.size(), directed[i]);
        wait_drained();

        // narrow storage, deep load: strong affinity on a small pool
        write_limit(CFG_STORAGE_LIMIT, 7'd3);
        write_limit(CFG_LOAD_LIMIT, 7'd127);
        queue_ids(400, 8, ID_W'($urandom_range(0, 1023)));
        wait_drained();

        // widest legal storage, full id range
        write_limit(CFG_STORAGE_LIMIT, 7'd64);
        queue_ids(400, 0, '0);
        wait_drained();

        // storage above the slot count, mid load
        write_limit(CFG_STORAGE_LIMIT, 7'd127);
        write_limit(CFG_LOAD_LIMIT, 7'd100);
        queue_ids(300, 40, ID_W'($urandom_range(0, 1023)));
        wait_drained();

        // storage zero: only ids already held can join a machine
        write_limit(CFG_STORAGE_LIMIT, 7'd0);
        write_limit(CFG_LOAD_LIMIT, 7'd127);
        queue_ids(200, 6, ID_W'($urandom_range(0, 1023)));
        wait_drained();

        // load zero: every item opens a machine until none is left
        write_limit(CFG_STORAGE_LIMIT, 7'd1);
        write_limit(CFG_LOAD_LIMIT, 7'd0);
        queue_ids(150, 0, '0);
        wait_drained();

        // full table, limits relaxed again
        write_limit(CFG_STORAGE_LIMIT, 7'd64);
        write_limit(CFG_LOAD_LIMIT, 7'd1);
        queue_ids(50, 0, '0);
        wait_drained();
        write_limit(CFG_LOAD_LIMIT, 7'd127);
        queue_ids(150, 16, '0);
        wait_drained();

        repeat (200) @(posedge clk);
        $display("sent %0d task ids, checked %0d placements", ids_sent, places_checked);
        $display("machines opened %0d, no-room results %0d, mismatches %0d",
                 opens_seen, full_seen, failures);
        if (failures == 0 && expected_places.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ffp_pkg.sv
rtl/ffp_if.sv
rtl/ffp_cell.sv
rtl/first_fit_task_placement_unit.sv
test/first_fit_task_placement_unit_test.sv
